>>> rtl/core/ipv4hc_pkg.sv
`timescale 1ns / 1ps

package ipv4hc_pkg;

    // header field constants
    localparam logic [3:0]  IPV4_VERSION     = 4'h4;
    localparam logic [3:0]  IPV4_BASE_IHL    = 4'h5;
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [12:0] FRAG_OFFSET_ONE  = 13'd1;
    localparam logic [7:0]  TTL_LAST_HOP     = 8'd1;
    localparam logic [15:0] CSUM_GOOD        = 16'hffff;

    // error codes, higher code wins
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OPTIONS  = 3'd1;
    localparam logic [2:0] ERR_VERSION  = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM = 3'd3;
    localparam logic [2:0] ERR_FRAGONE  = 3'd4;
    localparam logic [2:0] ERR_TTL      = 3'd5;
    localparam logic [2:0] ERR_SHORT    = 3'd6;
    localparam logic [2:0] ERR_LENGTH   = 3'd7;

    // dispositions
    localparam logic [1:0] DISP_FORWARD = 2'd0;
    localparam logic [1:0] DISP_PUNT    = 2'd1;
    localparam logic [1:0] DISP_DROP    = 2'd2;

    // field checks resolved in the first stage
    typedef struct packed {
        logic options;
        logic version;
        logic frag_one;
        logic ttl;
        logic short_len;
        logic buf_short;
    } t_flags;

    // stage load enables handed to the checksum pipe
    typedef struct packed {
        logic adv1;
        logic adv2;
    } t_stage_ctl;

endpackage

>>> rtl/core/ipv4hc_if.sv
`timescale 1ns / 1ps

// header item channel
interface ipv4hc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word0;
    logic [31:0] header_word1;
    logic [31:0] header_word2;
    logic [31:0] header_word3;
    logic [31:0] header_word4;
    logic [15:0] buffer_length;
    logic [7:0]  forward_next;

    modport source (
        output valid, header_word0, header_word1, header_word2, header_word3,
               header_word4, buffer_length, forward_next,
        input  ready
    );
    modport sink (
        input  valid, header_word0, header_word1, header_word2, header_word3,
               header_word4, buffer_length, forward_next,
        output ready
    );
endinterface

// result item channel
interface ipv4hc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] disposition;
    logic [2:0] error_code;
    logic [7:0] next_hop;

    modport source (
        output valid, disposition, error_code, next_hop,
        input  ready
    );
    modport sink (
        input  valid, disposition, error_code, next_hop,
        output ready
    );
endinterface

>>> rtl/core/ipv4hc_csum.sv
`timescale 1ns / 1ps

module ipv4hc_csum (
    input  logic                   i_clk,
    input  ipv4hc_pkg::t_stage_ctl i_ctl,
    input  logic [31:0]            i_word0,
    input  logic [31:0]            i_word1,
    input  logic [31:0]            i_word2,
    input  logic [31:0]            i_word3,
    input  logic [31:0]            i_word4,
    output logic [16:0]            o_fold
);
    import ipv4hc_pkg::*;

    logic [16:0] r_pair [5];
    logic [16:0] r_fold;
    logic [16:0] n_pair [5];
    logic [19:0] n_total;
    logic [16:0] n_fold;

    // stage 1: add the two halves of each word
    always_comb begin
        n_pair[0] = {1'b0, i_word0[31:16]} + {1'b0, i_word0[15:0]};
        n_pair[1] = {1'b0, i_word1[31:16]} + {1'b0, i_word1[15:0]};
        n_pair[2] = {1'b0, i_word2[31:16]} + {1'b0, i_word2[15:0]};
        n_pair[3] = {1'b0, i_word3[31:16]} + {1'b0, i_word3[15:0]};
        n_pair[4] = {1'b0, i_word4[31:16]} + {1'b0, i_word4[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_pair <= n_pair;
        end
    end

    // stage 2: sum the pairs and fold the upper nibble back in once
    always_comb begin
        n_total = {3'b0, r_pair[0]} + {3'b0, r_pair[1]} + {3'b0, r_pair[2]}
                + {3'b0, r_pair[3]} + {3'b0, r_pair[4]};
        n_fold  = {1'b0, n_total[15:0]} + {13'b0, n_total[19:16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_fold <= n_fold;
        end
    end

    assign o_fold = r_fold;

endmodule

>>> rtl/core/ipv4_header_check.sv
`timescale 1ns / 1ps

// IPv4 fixed-header checker. Each item carries the 20-byte header as five
// big-endian words plus the received length and the next index to use on
// success; the result gives forward, punt (options present) or drop, with
// the highest-ranked error code. Three register stages: word-half sums and
// field compares, the checksum add and first fold, then the final fold,
// error priority and the output register. One item is taken every cycle
// while the output is not stalled, and a stalled output holds the pipe back
// through the ready chain without losing or repeating items. check_enable
// resets to 1; write it only while no item is in flight (not enforced).
module ipv4_header_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    ipv4hc_in_if.sink       i_item,
    ipv4hc_out_if.source    o_item
);
    import ipv4hc_pkg::*;

    logic        r_check_enable;
    logic        r_v1, r_v2, r_v3;
    t_flags      r_flags1, r_flags2;
    logic [7:0]  r_fwd1, r_fwd2;
    logic [1:0]  r_disp;
    logic [2:0]  r_err;
    logic [7:0]  r_next;
    t_stage_ctl  ctl;
    logic        adv3;
    t_flags      n_flags1;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic        csum_bad;
    logic [2:0]  n_err;
    logic [1:0]  n_disp;
    logic [7:0]  n_next;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_enable <= i_cfg_wdata;
        end
    end

    // stage advance: a stage loads when empty or when its content moves on
    assign adv3     = !r_v3 || o_item.ready;
    assign ctl.adv2 = !r_v2 || adv3;
    assign ctl.adv1 = !r_v1 || ctl.adv2;
    assign i_item.ready = ctl.adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ctl.adv1) begin
                r_v1 <= i_item.valid;
            end
            if (ctl.adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: field compares
    always_comb begin
        n_flags1.options   = i_item.header_word0[27:24] != IPV4_BASE_IHL;
        n_flags1.version   = i_item.header_word0[31:28] != IPV4_VERSION;
        n_flags1.frag_one  = i_item.header_word1[12:0] == FRAG_OFFSET_ONE;
        n_flags1.ttl       = i_item.header_word2[31:24] <= TTL_LAST_HOP;
        n_flags1.short_len = i_item.header_word0[15:0] < MIN_HEADER_BYTES;
        n_flags1.buf_short = i_item.buffer_length < i_item.header_word0[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv1) begin
            r_flags1 <= n_flags1;
            r_fwd1   <= i_item.forward_next;
        end
        if (ctl.adv2) begin
            r_flags2 <= r_flags1;
            r_fwd2   <= r_fwd1;
        end
    end

    // checksum adder pipe, stages 1 and 2
    ipv4hc_csum u_csum (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_word0 (i_item.header_word0),
        .i_word1 (i_item.header_word1),
        .i_word2 (i_item.header_word2),
        .i_word3 (i_item.header_word3),
        .i_word4 (i_item.header_word4),
        .o_fold  (fold1)
    );

    // stage 3: last fold, error priority, disposition
    always_comb begin
        fold2    = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
        csum_bad = r_check_enable && (fold2[16] || (fold2[15:0] != CSUM_GOOD));

        n_err = ERR_NONE;
        if (r_flags2.options)   n_err = ERR_OPTIONS;
        if (r_flags2.version)   n_err = ERR_VERSION;
        if (csum_bad)           n_err = ERR_CHECKSUM;
        if (r_flags2.frag_one)  n_err = ERR_FRAGONE;
        if (r_flags2.ttl)       n_err = ERR_TTL;
        if (r_flags2.short_len) n_err = ERR_SHORT;
        if (r_flags2.buf_short) n_err = ERR_LENGTH;

        case (n_err)
            ERR_NONE: begin
                n_disp = DISP_FORWARD;
                n_next = r_fwd2;
            end
            ERR_OPTIONS: begin
                n_disp = DISP_PUNT;
                n_next = 8'd0;
            end
            default: begin
                n_disp = DISP_DROP;
                n_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_disp <= n_disp;
            r_err  <= n_err;
            r_next <= n_next;
        end
    end

    assign o_item.valid       = r_v3;
    assign o_item.disposition = r_disp;
    assign o_item.error_code  = r_err;
    assign o_item.next_hop    = r_next;

    // pipe is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline valid bits not cleared by reset");

    // forward exactly when no error
    a_fwd_iff_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_disp == DISP_FORWARD) == (r_err == ERR_NONE)))
        else $error("disposition and error code disagree");

    // punt only for options
    a_punt_options: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (r_disp == DISP_PUNT)) |-> (r_err == ERR_OPTIONS))
        else $error("punt without options error");

    // a nonzero next index only on a clean header
    a_next_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (r_next != 8'd0)) |-> (r_err == ERR_NONE))
        else $error("next index set on a failed header");

    // a stage holding an item under stall keeps it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !ctl.adv2) |=> r_v2)
        else $error("middle stage item lost under stall");

endmodule

>>> verif/ipv4_header_check_tb.sv
`timescale 1ns / 1ps

module ipv4_header_check_tb;

    import ipv4hc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD_OFF = 300;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 285;
    localparam int TAIL_CYCLES   = 12;

    // directed row actions on the checksum enable
    localparam logic [1:0] CFG_KEEP = 2'd0;
    localparam logic [1:0] CFG_OFF  = 2'd1;
    localparam logic [1:0] CFG_ON   = 2'd2;

    localparam logic [31:0] BASE_W0  = 32'h4500_0054;
    localparam logic [31:0] BASE_W1  = 32'h1c46_4000;
    localparam logic [31:0] BASE_W2  = 32'h4006_0000;
    localparam logic [31:0] SRC_ADDR = 32'hc0a8_0001;
    localparam logic [31:0] DST_ADDR = 32'hc0a8_00c7;

    typedef struct packed {
        logic [4:0][31:0] word;
        logic [15:0]      buf_len;
        logic [7:0]       fwd_next;
    } t_header;

    typedef struct packed {
        logic [1:0] disp;
        logic [2:0] err;
        logic [7:0] next;
    } t_verdict;

    typedef struct packed {
        logic [1:0] cfg_op;
        logic       seal;
        logic       typed;
        t_header    hdr;
        t_verdict   verdict;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ipv4hc_in_if  hdr_ch ();
    ipv4hc_out_if verdict_ch ();

    ipv4_header_check DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (hdr_ch),
        .o_item      (verdict_ch)
    );

    t_verdict pending_verdicts[$];
    t_row     directed_rows[$];
    logic     csum_check_on;
    bit       idle_on;
    bit       hold_off_request;
    int       fault_count;
    int       cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ipv4_header_check regression: fail");
            $finish;
        end
    end

    // ones' complement sum of the ten header halfwords, folded to 16 bits
    function automatic logic [15:0] halfword_sum(input t_header h);
        logic [19:0] acc;
        acc = '0;
        for (int i = 0; i < 5; i++)
            acc = acc + h.word[i][31:16] + h.word[i][15:0];
        while (acc > 20'hffff)
            acc = acc[15:0] + acc[19:16];
        return acc[15:0];
    endfunction

    // fill the checksum field so the header sums to all ones
    function automatic t_header seal_checksum(input t_header h);
        h.word[2][15:0] = 16'h0000;
        h.word[2][15:0] = ~halfword_sum(h);
        return h;
    endfunction

    // expected disposition, error and next index for one header
    function automatic t_verdict predict_verdict(input t_header h, input logic csum_on);
        logic [2:0] err;
        t_verdict   v;
        err = ERR_NONE;
        if (h.word[0][27:24] != IPV4_BASE_IHL)
            err = ERR_OPTIONS;
        if (h.word[0][31:28] != IPV4_VERSION)
            err = ERR_VERSION;
        if (csum_on && halfword_sum(h) != CSUM_GOOD)
            err = ERR_CHECKSUM;
        if (h.word[1][12:0] == FRAG_OFFSET_ONE)
            err = ERR_FRAGONE;
        if (h.word[2][31:24] <= TTL_LAST_HOP)
            err = ERR_TTL;
        if (h.word[0][15:0] < MIN_HEADER_BYTES)
            err = ERR_SHORT;
        if (h.buf_len < h.word[0][15:0])
            err = ERR_LENGTH;
        v.err = err;
        if (err == ERR_NONE) begin
            v.disp = DISP_FORWARD;
            v.next = h.fwd_next;
        end else begin
            v.disp = (err == ERR_OPTIONS) ? DISP_PUNT : DISP_DROP;
            v.next = 8'h00;
        end
        return v;
    endfunction

    function automatic void add_row(input logic [1:0] cfg_op, input logic seal,
                                    input logic [31:0] w0, input logic [31:0] w1,
                                    input logic [31:0] w2, input logic [31:0] w3,
                                    input logic [31:0] w4, input logic [15:0] blen,
                                    input logic [7:0] fwd, input logic typed,
                                    input logic [1:0] disp, input logic [2:0] err,
                                    input logic [7:0] next);
        t_row r;
        r.cfg_op       = cfg_op;
        r.seal         = seal;
        r.typed        = typed;
        r.hdr.word     = {w4, w3, w2, w1, w0};
        r.hdr.buf_len  = blen;
        r.hdr.fwd_next = fwd;
        r.verdict      = '{disp: disp, err: err, next: next};
        directed_rows.push_back(r);
    endfunction

    // present one header item, with a random gap first, until accepted
    task automatic offer_header(input t_header h, input t_verdict want);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 93)
                gap = $urandom_range(8, 40);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        hdr_ch.valid         <= 1'b1;
        hdr_ch.header_word0  <= h.word[0];
        hdr_ch.header_word1  <= h.word[1];
        hdr_ch.header_word2  <= h.word[2];
        hdr_ch.header_word3  <= h.word[3];
        hdr_ch.header_word4  <= h.word[4];
        hdr_ch.buffer_length <= h.buf_len;
        hdr_ch.forward_next  <= h.fwd_next;
        @(posedge i_clk);
        while (!hdr_ch.ready)
            @(posedge i_clk);
        pending_verdicts.push_back(want);
        @(negedge i_clk);
    endtask

    // write the checksum enable once the pipe has emptied
    task automatic set_check_enable(input logic value);
        hdr_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        csum_check_on = value;
    endtask

    // result sink with random stalls and one long hold-off on request
    initial begin : verdict_sink
        int   hold;
        int   r;
        logic rdy;
        hold = 0;
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                rdy = 1'b0;
            end else if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold = LONG_HOLD_OFF - 1;
                rdy = 1'b0;
            end else if (!idle_on) begin
                rdy = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    rdy = 1'b1;
                end else if (r < 92) begin
                    hold = $urandom_range(0, 2);
                    rdy = 1'b0;
                end else begin
                    hold = $urandom_range(7, 39);
                    rdy = 1'b0;
                end
            end
            verdict_ch.ready <= rdy;
        end
    end

    // compare each accepted result with the oldest expected verdict
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result disp %0d err %0d next %0d", $time,
                         verdict_ch.disposition, verdict_ch.error_code,
                         verdict_ch.next_hop);
                fault_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict_ch.disposition !== want.disp) begin
                    $display("%0t: disposition expected %0d actual %0d", $time,
                             want.disp, verdict_ch.disposition);
                    fault_count++;
                end
                if (verdict_ch.error_code !== want.err) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.err, verdict_ch.error_code);
                    fault_count++;
                end
                if (verdict_ch.next_hop !== want.next) begin
                    $display("%0t: next_hop expected %0d actual %0d", $time,
                             want.next, verdict_ch.next_hop);
                    fault_count++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_header  h;
        t_verdict want;
        t_row     row;
        int       r;
        int       total;
        int       blen;
        int       frag;
        int       pick;
        int       faults;
        logic     bad_csum;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = 1'b0;
        hdr_ch.valid         = 1'b0;
        hdr_ch.header_word0  = '0;
        hdr_ch.header_word1  = '0;
        hdr_ch.header_word2  = '0;
        hdr_ch.header_word3  = '0;
        hdr_ch.header_word4  = '0;
        hdr_ch.buffer_length = '0;
        hdr_ch.forward_next  = '0;
        csum_check_on        = 1'b1;
        idle_on              = 1'b1;
        hold_off_request     = 1'b0;
        fault_count          = 0;

        // clean header, extremes of every field, each error and mixed failures
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84, 8'hff,
                1, DISP_FORWARD, ERR_NONE, 8'hff);
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84, 8'h00,
                1, DISP_FORWARD, ERR_NONE, 8'h00);
        add_row(CFG_KEEP, 1, 32'h4600_0054, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h11, 1, DISP_PUNT, ERR_OPTIONS, 8'h00);
        add_row(CFG_KEEP, 1, 32'h4f00_0054, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h22, 1, DISP_PUNT, ERR_OPTIONS, 8'h00);
        add_row(CFG_KEEP, 1, 32'h6500_0054, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h33, 1, DISP_DROP, ERR_VERSION, 8'h00);
        add_row(CFG_KEEP, 1, 32'h0000_0054, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h44, 1, DISP_DROP, ERR_VERSION, 8'h00);
        add_row(CFG_KEEP, 0, BASE_W0, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84, 8'h55,
                0, 2'd0, 3'd0, 8'h00);
        add_row(CFG_KEEP, 1, BASE_W0, 32'h1c46_0001, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h66, 1, DISP_DROP, ERR_FRAGONE, 8'h00);
        add_row(CFG_KEEP, 1, BASE_W0, 32'h1c46_3fff, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h77, 1, DISP_FORWARD, ERR_NONE, 8'h77);
        add_row(CFG_KEEP, 1, BASE_W0, 32'h0000_0002, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h88, 1, DISP_FORWARD, ERR_NONE, 8'h88);
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, 32'h0106_0000, SRC_ADDR, DST_ADDR, 16'd84,
                8'h99, 1, DISP_DROP, ERR_TTL, 8'h00);
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, 32'h0006_0000, SRC_ADDR, DST_ADDR, 16'd84,
                8'haa, 1, DISP_DROP, ERR_TTL, 8'h00);
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, 32'h0206_0000, SRC_ADDR, DST_ADDR, 16'd84,
                8'hbb, 1, DISP_FORWARD, ERR_NONE, 8'hbb);
        add_row(CFG_KEEP, 1, BASE_W0, BASE_W1, 32'hffff_0000, SRC_ADDR, DST_ADDR, 16'd84,
                8'hcc, 1, DISP_FORWARD, ERR_NONE, 8'hcc);
        add_row(CFG_KEEP, 1, 32'h4500_0013, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'hdd, 1, DISP_DROP, ERR_SHORT, 8'h00);
        add_row(CFG_KEEP, 1, 32'h4500_0014, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd20,
                8'hee, 1, DISP_FORWARD, ERR_NONE, 8'hee);
        add_row(CFG_KEEP, 1, 32'h4500_0000, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd0,
                8'h01, 1, DISP_DROP, ERR_SHORT, 8'h00);
        add_row(CFG_KEEP, 1, 32'h4500_ffff, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'hffff,
                8'h02, 1, DISP_FORWARD, ERR_NONE, 8'h02);
        add_row(CFG_KEEP, 1, 32'h4500_ffff, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'hfffe,
                8'h03, 1, DISP_DROP, ERR_LENGTH, 8'h00);
        // all-zero header fails the checksum, but the short length outranks it
        add_row(CFG_KEEP, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 8'h00,
                1, DISP_DROP, ERR_SHORT, 8'h00);
        // all-ones header sums to all ones, so the checksum passes and the version error outranks options
        add_row(CFG_KEEP, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 16'hffff, 8'hff, 1, DISP_DROP, ERR_VERSION, 8'h00);
        add_row(CFG_KEEP, 0, 32'h6600_0064, BASE_W1, 32'h0006_0000, SRC_ADDR, DST_ADDR,
                16'd50, 8'h04, 1, DISP_DROP, ERR_LENGTH, 8'h00);
        // checksum ignored while disabled
        add_row(CFG_OFF, 0, BASE_W0, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84, 8'h05,
                1, DISP_FORWARD, ERR_NONE, 8'h05);
        add_row(CFG_KEEP, 0, 32'h4700_0054, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84,
                8'h06, 1, DISP_PUNT, ERR_OPTIONS, 8'h00);
        add_row(CFG_ON, 0, BASE_W0, BASE_W1, BASE_W2, SRC_ADDR, DST_ADDR, 16'd84, 8'h07,
                0, 2'd0, 3'd0, 8'h00);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.cfg_op == CFG_OFF)
                set_check_enable(1'b0);
            else if (row.cfg_op == CFG_ON)
                set_check_enable(1'b1);
            h = row.seal ? seal_checksum(row.hdr) : row.hdr;
            want = row.typed ? row.verdict : predict_verdict(h, csum_check_on);
            offer_header(h, want);
        end

        // random part: fully random headers, well-formed headers and some with injected faults
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_check_enable(p[0] ? 1'b1 : 1'b0);
            if (p == 2)
                hold_off_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 100 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    for (int i = 0; i < 5; i++)
                        h.word[i] = $urandom;
                    h.buf_len  = 16'($urandom);
                    h.fwd_next = 8'($urandom);
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        total = $urandom_range(20, 65535);
                    else
                        total = $urandom_range(20, 1500);
                    if ($urandom_range(0, 3) == 0)
                        blen = $urandom_range(total, 65535);
                    else if (total > 65535 - 64)
                        blen = 65535;
                    else
                        blen = total + $urandom_range(0, 64);
                    frag = $urandom_range(0, 8191);
                    if (frag == 1)
                        frag = 0;
                    h.word[0]  = {IPV4_VERSION, IPV4_BASE_IHL, 8'($urandom), 16'(total)};
                    h.word[1]  = {16'($urandom), 3'($urandom), 13'(frag)};
                    h.word[2]  = {8'($urandom_range(2, 255)), 8'($urandom), 16'h0000};
                    h.word[3]  = $urandom;
                    h.word[4]  = $urandom;
                    h.fwd_next = 8'($urandom);
                    bad_csum   = 1'b0;
                    if (r >= 55) begin
                        faults = ($urandom_range(0, 3) == 0) ? 2 : 1;
                        repeat (faults) begin
                            case (3'($urandom_range(1, 7)))
                                ERR_OPTIONS: begin
                                    pick = $urandom_range(0, 14);
                                    h.word[0][27:24] = (pick >= 5) ? 4'(pick + 1) : 4'(pick);
                                end
                                ERR_VERSION: begin
                                    pick = $urandom_range(0, 14);
                                    h.word[0][31:28] = (pick >= 4) ? 4'(pick + 1) : 4'(pick);
                                end
                                ERR_CHECKSUM: bad_csum = 1'b1;
                                ERR_FRAGONE: h.word[1][12:0] = FRAG_OFFSET_ONE;
                                ERR_TTL: h.word[2][31:24] = 8'($urandom_range(0, 1));
                                ERR_SHORT: begin
                                    total = $urandom_range(0, 19);
                                    h.word[0][15:0] = 16'(total);
                                end
                                ERR_LENGTH: begin
                                    if (total == 0) begin
                                        total = 20;
                                        h.word[0][15:0] = 16'(total);
                                    end
                                    blen = $urandom_range(0, total - 1);
                                end
                                default: ;
                            endcase
                        end
                    end
                    h.buf_len = 16'(blen);
                    h = seal_checksum(h);
                    if (bad_csum)
                        h.word[2][15:0] = h.word[2][15:0] ^ 16'($urandom_range(1, 65535));
                end
                want = predict_verdict(h, csum_check_on);
                offer_header(h, want);
            end
        end

        // drain and let any stray result show up
        hdr_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fault_count == 0)
            $display("ipv4_header_check regression: pass");
        else
            $display("ipv4_header_check regression: fail");
        $finish;
    end

endmodule
